FILE: sv/mtc_pkg.sv
// shared widths, constants and register codes of the magnetometer trim compensation block
package mtc_pkg;

  localparam int unsigned RAW_W     = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIM_XY_OFFSETS,
    REG_TRIM_XY_SHAPE,
    REG_TRIM_Z_GAIN,
    REG_TRIM_Z_OFFSET,
    REG_TRIM_RESISTANCE_REF,
    REG_BIAS_XY,
    REG_BIAS_Z
  } cfg_reg_e;

  // divider geometry: quotient bits resolved per stage
  localparam int unsigned DIV_STEP    = 3;
  localparam int unsigned TEMP_SHIFT  = 14;
  localparam int unsigned TDIV_DEN_W  = 16;
  localparam int unsigned TDIV_NUM_W  = TDIV_DEN_W + TEMP_SHIFT;
  localparam int unsigned TDIV_STAGES = (TDIV_NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned ZDIV_NUM_W  = 33;
  localparam int unsigned ZDIV_DEN_W  = 17;
  localparam int unsigned ZDIV_STAGES = (ZDIV_NUM_W + DIV_STEP - 1) / DIV_STEP;

  // raw x/y words are needed again three stages after the temperature quotient
  localparam int unsigned MXY_DLY = TDIV_STAGES + 3;

  localparam logic [15:0]        TEMP_OFFSET = 16'h4000;
  localparam logic signed [25:0] A_OFFSET    = 26'sh010_0000;
  localparam logic signed [9:0]  SHAPE_BIAS  = 10'sd160;
  localparam logic [31:0]        Z_ROUND     = 32'd32768;
  localparam int unsigned        Z_NUM_SHIFT = 15;
  localparam int unsigned        C_SHIFT     = 13;

endpackage

FILE: sv/mtc_div.sv
// pipelined unsigned restoring divider, StepW quotient bits per stage
module mtc_div #(
  parameter int unsigned NumW  = 30,
  parameter int unsigned DenW  = 16,
  parameter int unsigned StepW = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned Stages = (NumW + StepW - 1) / StepW;
  localparam int unsigned PadW   = Stages * StepW;

  logic            valid_q [Stages];
  logic [DenW-1:0] rem_q   [Stages];
  logic [PadW-1:0] nq_q    [Stages];
  logic [DenW-1:0] den_q   [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic            valid_in;
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [PadW-1:0] nq_in;
    logic [DenW-1:0] rem_d;
    logic [PadW-1:0] nq_d;

    if (s == 0) begin : g_head
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign nq_in    = PadW'(num_i);
      assign den_in   = den_i;
    end else begin : g_body
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign nq_in    = nq_q[s-1];
      assign den_in   = den_q[s-1];
    end

    // numerator bits shift out at the top, quotient bits shift in at the bottom
    always_comb begin
      logic [DenW:0] trial;
      trial = '0;
      rem_d = rem_in;
      nq_d  = nq_in;
      for (int k = 0; k < StepW; k++) begin
        trial = {rem_d, nq_d[PadW-1]};
        nq_d  = {nq_d[PadW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_d   = DenW'(trial - {1'b0, den_in});
          nq_d[0] = 1'b1;
        end else begin
          rem_d = trial[DenW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      nq_q[s]  <= nq_d;
      den_q[s] <= den_in;
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign quo_o   = nq_q[Stages-1][NumW-1:0];

endmodule

FILE: sv/magnetometer_trim_compensation_top.sv
// top level: trim-based temperature compensation of raw magnetometer samples
// done_o strobes for each request taken: an edge with start and raw hall bit 0 both high
// throughput: one request per cycle; busy never rises and the result path never stalls
// results pass the 10-stage temperature divider and five further stages, matched by
// z product registers and the 11-stage z divider; both resolve three bits per stage
// reset clears the valid pipeline and all trim and bias registers to zero
module magnetometer_trim_compensation_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [mtc_pkg::RAW_W-1:0]         raw_x_word_i,
  input  logic [mtc_pkg::RAW_W-1:0]         raw_y_word_i,
  input  logic [mtc_pkg::RAW_W-1:0]         raw_z_word_i,
  input  logic [mtc_pkg::RAW_W-1:0]         raw_hall_word_i,
  input  logic                              cfg_we_i,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mtc_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic                              done_o,
  output logic signed [mtc_pkg::RAW_W-1:0]  field_x_o,
  output logic signed [mtc_pkg::RAW_W-1:0]  field_y_o,
  output logic signed [mtc_pkg::RAW_W-1:0]  field_z_o
);

  import mtc_pkg::*;

  typedef struct packed {
    logic signed [12:0] mx;
    logic signed [12:0] my;
  } mxy_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } zsign_t;

  // configuration registers
  logic [15:0] offs_q;
  logic [31:0] shape_q;
  logic [31:0] zgain_q;
  logic [31:0] zoff_q;
  logic [15:0] rref_q;
  logic [31:0] bias_xy_q;
  logic [15:0] bias_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q    <= '0;
      shape_q   <= '0;
      zgain_q   <= '0;
      zoff_q    <= '0;
      rref_q    <= '0;
      bias_xy_q <= '0;
      bias_z_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIM_XY_OFFSETS:     offs_q    <= cfg_wdata_i[15:0];
        REG_TRIM_XY_SHAPE:       shape_q   <= cfg_wdata_i;
        REG_TRIM_Z_GAIN:         zgain_q   <= cfg_wdata_i;
        REG_TRIM_Z_OFFSET:       zoff_q    <= cfg_wdata_i;
        REG_TRIM_RESISTANCE_REF: rref_q    <= cfg_wdata_i[15:0];
        REG_BIAS_XY:             bias_xy_q <= cfg_wdata_i;
        REG_BIAS_Z:              bias_z_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [7:0]  x1, y1, x2, y2, xy2;
  logic [7:0]         xy1;
  logic [15:0]        z1, xyz1;
  logic signed [15:0] z2, z3, z4, xyz1_s, bias_x, bias_y, bias_z;

  assign x1     = offs_q[7:0];
  assign y1     = offs_q[15:8];
  assign x2     = shape_q[7:0];
  assign y2     = shape_q[15:8];
  assign xy1    = shape_q[23:16];
  assign xy2    = shape_q[31:24];
  assign z1     = zgain_q[15:0];
  assign z2     = zgain_q[31:16];
  assign z3     = zoff_q[15:0];
  assign z4     = zoff_q[31:16];
  assign xyz1   = rref_q;
  assign xyz1_s = rref_q;
  assign bias_x = bias_xy_q[15:0];
  assign bias_y = bias_xy_q[31:16];
  assign bias_z = bias_z_q;

  assign busy = 1'b0;

  // stage 0: field extraction
  logic               v0_q;
  logic signed [12:0] mx0_q, my0_q;
  logic signed [14:0] mz0_q;
  logic [13:0]        r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start & raw_hall_word_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    mx0_q <= raw_x_word_i[15:3];
    my0_q <= raw_y_word_i[15:3];
    mz0_q <= raw_z_word_i[15:1];
    r0_q  <= raw_hall_word_i[15:2];
  end

  // temperature quotient
  logic [TDIV_DEN_W-1:0] tden;
  logic [TDIV_NUM_W-1:0] tnum;
  logic                  tdiv_valid;
  logic [TDIV_NUM_W-1:0] tquo;

  assign tden = (r0_q != '0) ? TDIV_DEN_W'(r0_q) : xyz1;
  assign tnum = {xyz1, {TEMP_SHIFT{1'b0}}};

  mtc_div #(
    .NumW  (TDIV_NUM_W),
    .DenW  (TDIV_DEN_W),
    .StepW (DIV_STEP)
  ) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .num_i   (tnum),
    .den_i   (tden),
    .valid_o (tdiv_valid),
    .quo_o   (tquo)
  );

  mxy_t mxy_dly_q [MXY_DLY];
  logic tz_dly_q  [TDIV_STAGES];

  always_ff @(posedge clk_i) begin
    mxy_dly_q[0].mx <= mx0_q;
    mxy_dly_q[0].my <= my0_q;
    for (int i = 1; i < MXY_DLY; i++) begin
      mxy_dly_q[i] <= mxy_dly_q[i-1];
    end
    tz_dly_q[0] <= (tden == '0);
    for (int i = 1; i < TDIV_STAGES; i++) begin
      tz_dly_q[i] <= tz_dly_q[i-1];
    end
  end

  // xy path valid bits, one per stage after the divider
  logic xv_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        xv_q[i] <= 1'b0;
      end
    end else begin
      xv_q[0] <= tdiv_valid;
      for (int i = 1; i < 5; i++) begin
        xv_q[i] <= xv_q[i-1];
      end
    end
  end

  // temperature term, square and linear products
  logic [15:0]        tq16;
  logic signed [15:0] temp;
  logic signed [31:0] sq_d, sq_q;
  logic signed [24:0] pt_d, pt_q;

  assign tq16 = tz_dly_q[TDIV_STAGES-1] ? '0 : tquo[15:0];
  assign temp = tq16 - TEMP_OFFSET;
  assign sq_d = 32'(temp) * 32'(temp);
  assign pt_d = 25'(temp) * $signed(25'(xy1));

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    pt_q <= pt_d;
  end

  // shared shape term
  logic signed [33:0] shape_sum;
  logic signed [25:0] a_d, a_q;

  assign shape_sum = 34'(xy2) * 34'(sq_q >>> 7) + (34'(pt_q) <<< 7);
  assign a_d       = 26'(shape_sum >>> 9) + A_OFFSET;

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  // per-axis gain
  logic signed [9:0]  kx, ky;
  logic signed [23:0] bx_d, by_d, bx_q, by_q;

  assign kx   = 10'(x2) + SHAPE_BIAS;
  assign ky   = 10'(y2) + SHAPE_BIAS;
  assign bx_d = 24'((36'(a_q) * 36'(kx)) >>> 12);
  assign by_d = 24'((36'(a_q) * 36'(ky)) >>> 12);

  always_ff @(posedge clk_i) begin
    bx_q <= bx_d;
    by_q <= by_d;
  end

  // raw axis times gain
  logic signed [36:0] px, py;
  logic signed [15:0] cx_q, cy_q;

  assign px = 37'($signed(mxy_dly_q[MXY_DLY-1].mx)) * 37'(bx_q);
  assign py = 37'($signed(mxy_dly_q[MXY_DLY-1].my)) * 37'(by_q);

  always_ff @(posedge clk_i) begin
    cx_q <= px[C_SHIFT+15:C_SHIFT];
    cy_q <= py[C_SHIFT+15:C_SHIFT];
  end

  // x and y offsets and bias
  logic signed [15:0] fx_d, fy_d, fx_q, fy_q;

  assign fx_d = cx_q + (16'(x1) <<< 3) - bias_x;
  assign fy_d = cy_q + (16'(y1) <<< 3) - bias_y;

  always_ff @(posedge clk_i) begin
    if (xv_q[3]) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
    end
  end

  // z path valid bits ahead of its divider
  logic zv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        zv_q[i] <= 1'b0;
      end
    end else begin
      zv_q[0] <= v0_q;
      for (int i = 1; i < 3; i++) begin
        zv_q[i] <= zv_q[i-1];
      end
    end
  end

  // z products
  logic signed [16:0] rdiff;
  logic [30:0]        pz1_d, pz1_q;
  logic signed [32:0] pz3_d, pz3_q;
  logic signed [16:0] dzv_d, dzv_q;

  assign rdiff = $signed({3'b000, r0_q}) - 17'(xyz1_s);
  assign pz1_d = 31'(z1) * 31'({r0_q, 1'b0});
  assign pz3_d = 33'(z3) * 33'(rdiff);
  assign dzv_d = 17'(mz0_q) - 17'(z4);

  always_ff @(posedge clk_i) begin
    pz1_q <= pz1_d;
    pz3_q <= pz3_d;
    dzv_q <= dzv_d;
  end

  // z numerator and divisor
  logic [15:0]        zt;
  logic signed [33:0] num_d, num_q;
  logic signed [16:0] zd_d, zd_q;

  assign zt    = 16'((32'(pz1_q) + Z_ROUND) >> 16);
  assign num_d = (34'(dzv_q) <<< Z_NUM_SHIFT) - 34'(pz3_q >>> 2);
  assign zd_d  = 17'(z2) + 17'($signed(zt));

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    zd_q  <= zd_d;
  end

  // sign and magnitude split for the unsigned divider
  logic [ZDIV_NUM_W-1:0] nmag_q;
  logic [ZDIV_DEN_W-1:0] dmag_q;
  zsign_t                zsign_q;

  always_ff @(posedge clk_i) begin
    nmag_q       <= num_q[33] ? ZDIV_NUM_W'(-num_q) : ZDIV_NUM_W'(num_q);
    dmag_q       <= zd_q[16] ? ZDIV_DEN_W'(-zd_q) : ZDIV_DEN_W'(zd_q);
    zsign_q.neg  <= num_q[33] ^ zd_q[16];
    zsign_q.zero <= (zd_q == '0);
  end

  logic                  zdiv_valid;
  logic [ZDIV_NUM_W-1:0] zquo;

  mtc_div #(
    .NumW  (ZDIV_NUM_W),
    .DenW  (ZDIV_DEN_W),
    .StepW (DIV_STEP)
  ) u_zdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (zv_q[2]),
    .num_i   (nmag_q),
    .den_i   (dmag_q),
    .valid_o (zdiv_valid),
    .quo_o   (zquo)
  );

  zsign_t zs_dly_q [ZDIV_STAGES];

  always_ff @(posedge clk_i) begin
    zs_dly_q[0] <= zsign_q;
    for (int i = 1; i < ZDIV_STAGES; i++) begin
      zs_dly_q[i] <= zs_dly_q[i-1];
    end
  end

  // signed z quotient and bias
  logic [15:0]        zq16;
  logic signed [15:0] zsgn;
  logic signed [15:0] fz_d, fz_q;

  assign zq16 = zquo[15:0];
  assign zsgn = zs_dly_q[ZDIV_STAGES-1].zero ? '0 :
                (zs_dly_q[ZDIV_STAGES-1].neg ? 16'(-zq16) : zq16);
  assign fz_d = zsgn - bias_z;

  always_ff @(posedge clk_i) begin
    if (zdiv_valid) begin
      fz_q <= fz_d;
    end
  end

  assign done_o    = xv_q[4];
  assign field_x_o = fx_q;
  assign field_y_o = fy_q;
  assign field_z_o = fz_q;

endmodule
